@@ rtl/core/tscm_pkg.sv @@
// ============================================================================
// tscm_pkg - shared types, constants and functions for the toy SPN cipher
// Holds the S-boxes, the nibble permutation, register and mode codes.
// ============================================================================
package tscm_pkg;

    localparam int BLOCK_W   = 32;
    localparam int NIB_W     = 4;
    localparam int NUM_NIBS  = BLOCK_W / NIB_W;
    localparam int KEY_W     = 96;
    localparam int ROUNDS    = 4;
    localparam int RKEY_STEP = 16;  // round key r starts at key bit 16*r

    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 3;
    localparam int MODE_W    = 2;

    // register index (paddr[4:2])
    localparam logic [REG_IDX_W-1:0] REG_KEY_LOW  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEY_MID  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KEY_HIGH = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_IV       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MODE     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DIR      = 3'd5;

    // chaining modes; code 3 behaves as ECB
    localparam logic [MODE_W-1:0] MODE_ECB = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CBC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OFB = 2'd2;

    localparam logic DIR_ENCRYPT = 1'b1;

    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [NIB_W-1:0]   nib_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        block_t            iv;
        logic [MODE_W-1:0] mode;
        logic              dir;
    } cfg_t;

    localparam nib_t SBOX_FWD [16] = '{
        4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
        4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
    };
    localparam nib_t SBOX_INV [16] = '{
        4'hE, 4'h3, 4'h4, 4'h8, 4'h1, 4'hC, 4'hA, 4'hF,
        4'h7, 4'hD, 4'h9, 4'h6, 4'hB, 4'h2, 4'h0, 4'h5
    };
    // output nibble i takes input nibble PERM_SRC[i] (zero based)
    localparam logic [2:0] PERM_SRC [NUM_NIBS] = '{
        3'd0, 3'd3, 3'd4, 3'd6, 3'd2, 3'd5, 3'd1, 3'd7
    };

    function automatic block_t round_key(input logic [KEY_W-1:0] key, input int r);
        return key[RKEY_STEP*r +: BLOCK_W];
    endfunction

    function automatic block_t sub_fwd(input block_t v);
        block_t o;
        for (int i = 0; i < NUM_NIBS; i++) begin
            o[NIB_W*i +: NIB_W] = SBOX_FWD[v[NIB_W*i +: NIB_W]];
        end
        return o;
    endfunction

    function automatic block_t sub_inv(input block_t v);
        block_t o;
        for (int i = 0; i < NUM_NIBS; i++) begin
            o[NIB_W*i +: NIB_W] = SBOX_INV[v[NIB_W*i +: NIB_W]];
        end
        return o;
    endfunction

    function automatic block_t perm_fwd(input block_t v);
        block_t o;
        for (int i = 0; i < NUM_NIBS; i++) begin
            o[NIB_W*i +: NIB_W] = v[NIB_W*PERM_SRC[i] +: NIB_W];
        end
        return o;
    endfunction

    function automatic block_t perm_inv(input block_t v);
        block_t o;
        for (int i = 0; i < NUM_NIBS; i++) begin
            o[NIB_W*PERM_SRC[i] +: NIB_W] = v[NIB_W*i +: NIB_W];
        end
        return o;
    endfunction

endpackage

@@ rtl/core/tscm_cfg_regs.sv @@
// ============================================================================
// tscm_cfg_regs - APB configuration registers
// Key words, IV, chaining mode and direction; zero-wait writes and reads.
// ============================================================================
module tscm_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tscm_pkg::ADDR_W-1:0]  paddr,
    input  logic [tscm_pkg::DATA_W-1:0]  pwdata,
    output logic [tscm_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output tscm_pkg::cfg_t               cfg
);

    logic [tscm_pkg::REG_IDX_W-1:0] idx;
    logic                           wr_en;
    tscm_pkg::block_t               key_low_reg;
    tscm_pkg::block_t               key_mid_reg;
    tscm_pkg::block_t               key_high_reg;
    tscm_pkg::block_t               iv_reg;
    logic [tscm_pkg::MODE_W-1:0]    mode_reg;
    logic                           dir_reg;

    assign idx    = paddr[tscm_pkg::ADDR_W-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_mid_reg  <= '0;
            key_high_reg <= '0;
            iv_reg       <= '0;
            mode_reg     <= tscm_pkg::MODE_ECB;
            dir_reg      <= tscm_pkg::DIR_ENCRYPT;
        end
        else if (wr_en)
        begin
            unique case (idx)
                tscm_pkg::REG_KEY_LOW:  key_low_reg  <= pwdata;
                tscm_pkg::REG_KEY_MID:  key_mid_reg  <= pwdata;
                tscm_pkg::REG_KEY_HIGH: key_high_reg <= pwdata;
                tscm_pkg::REG_IV:       iv_reg       <= pwdata;
                tscm_pkg::REG_MODE:     mode_reg     <= pwdata[tscm_pkg::MODE_W-1:0];
                tscm_pkg::REG_DIR:      dir_reg      <= pwdata[0];
                default: ;  // unmapped: ignored
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            tscm_pkg::REG_KEY_LOW:  prdata = key_low_reg;
            tscm_pkg::REG_KEY_MID:  prdata = key_mid_reg;
            tscm_pkg::REG_KEY_HIGH: prdata = key_high_reg;
            tscm_pkg::REG_IV:       prdata = iv_reg;
            tscm_pkg::REG_MODE:
                prdata = {{(tscm_pkg::DATA_W-tscm_pkg::MODE_W){1'b0}}, mode_reg};
            tscm_pkg::REG_DIR:      prdata = {{(tscm_pkg::DATA_W-1){1'b0}}, dir_reg};
            default:                prdata = '0;
        endcase
    end

    assign cfg.key  = {key_high_reg, key_mid_reg, key_low_reg};
    assign cfg.iv   = iv_reg;
    assign cfg.mode = mode_reg;
    assign cfg.dir  = dir_reg;

endmodule

@@ rtl/core/tscm_fwd_core.sv @@
// ============================================================================
// tscm_fwd_core - forward cipher datapath
// Four rounds of key mix, S-box and nibble permutation, then a final key mix.
// ============================================================================
module tscm_fwd_core (
    input  logic [tscm_pkg::KEY_W-1:0] key,
    input  tscm_pkg::block_t           blk_in,
    output tscm_pkg::block_t           blk_out
);

    tscm_pkg::block_t state [tscm_pkg::ROUNDS+1];

    assign state[0] = blk_in;

    for (genvar r = 0; r < tscm_pkg::ROUNDS; r++)
    begin : g_round
        assign state[r+1] = tscm_pkg::perm_fwd(
            tscm_pkg::sub_fwd(state[r] ^ tscm_pkg::round_key(key, r)));
    end

    assign blk_out = state[tscm_pkg::ROUNDS] ^ tscm_pkg::round_key(key, tscm_pkg::ROUNDS);

endmodule

@@ rtl/core/tscm_inv_core.sv @@
// ============================================================================
// tscm_inv_core - inverse cipher datapath
// Final key mix undone first, then four inverse rounds in reverse order.
// ============================================================================
module tscm_inv_core (
    input  logic [tscm_pkg::KEY_W-1:0] key,
    input  tscm_pkg::block_t           blk_in,
    output tscm_pkg::block_t           blk_out
);

    tscm_pkg::block_t state [tscm_pkg::ROUNDS+1];

    assign state[tscm_pkg::ROUNDS] = blk_in ^ tscm_pkg::round_key(key, tscm_pkg::ROUNDS);

    for (genvar r = tscm_pkg::ROUNDS; r > 0; r--)
    begin : g_round
        assign state[r-1] = tscm_pkg::sub_inv(tscm_pkg::perm_inv(state[r]))
                            ^ tscm_pkg::round_key(key, r-1);
    end

    assign blk_out = state[0];

endmodule

@@ rtl/core/toy_spn_cipher_with_modes.sv @@
// ============================================================================
// toy_spn_cipher_with_modes - 32-bit toy SPN block cipher, ECB/CBC/OFB
// One block per transfer; chain register kept for CBC and OFB.
// ============================================================================
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+----------------------
//  input   | in_valid, in_ready, data_in, restart      | in_valid & in_ready
//  output  | out_valid, out_ready, data_out            | out_valid & out_ready
//  config  | psel, penable, pwrite, paddr, pwdata, ... | psel & penable & pready
//
//  data_out is registered: each block passes the input register, then the
//  output register; throughput is one block per cycle while the output is not
//  stalled. The full cipher (four rounds plus final key mix) plus the mode
//  XORs sit between the two, and the chain register updates as the block
//  enters the output register, so chaining never stalls. Reset clears both
//  valid flags, the chain register and the config registers (direction resets
//  to encrypt). A stalled output holds; the input register still takes a block
//  when it is empty or the output register is free or being drained.
//
module toy_spn_cipher_with_modes (
    input  logic                         clk,
    input  logic                         rst_n,
    // APB config
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tscm_pkg::ADDR_W-1:0]  paddr,
    input  logic [tscm_pkg::DATA_W-1:0]  pwdata,
    output logic [tscm_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    // input blocks
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tscm_pkg::BLOCK_W-1:0] data_in,
    input  logic                         restart,
    // output blocks
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tscm_pkg::BLOCK_W-1:0] data_out
);

    tscm_pkg::cfg_t   cfg;

    // input register
    logic             s1_valid_reg;
    tscm_pkg::block_t s1_data_reg;
    logic             s1_restart_reg;

    // output register and chain state
    logic             out_valid_reg;
    logic             out_valid_next;
    tscm_pkg::block_t out_data_reg;
    tscm_pkg::block_t chain_reg;
    tscm_pkg::block_t chain_next;

    tscm_pkg::block_t chain_cur;
    tscm_pkg::block_t fwd_in;
    tscm_pkg::block_t fwd_out;
    tscm_pkg::block_t inv_out;
    tscm_pkg::block_t result;

    logic             out_free;
    logic             advance;

    tscm_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake: stage 1 moves into the output register when it is free
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_data_reg    <= data_in;
            s1_restart_reg <= restart;
        end
    end

    // restart swaps in the IV before this block is processed
    assign chain_cur = s1_restart_reg ? cfg.iv : chain_reg;

    // forward core input: keystream in OFB, whitened block in CBC encrypt
    always_comb
    begin
        unique case (cfg.mode)
            tscm_pkg::MODE_OFB: fwd_in = chain_cur;
            tscm_pkg::MODE_CBC: fwd_in = s1_data_reg ^ chain_cur;
            default:            fwd_in = s1_data_reg;
        endcase
    end

    tscm_fwd_core u_fwd (
        .key     (cfg.key),
        .blk_in  (fwd_in),
        .blk_out (fwd_out)
    );

    tscm_inv_core u_inv (
        .key     (cfg.key),
        .blk_in  (s1_data_reg),
        .blk_out (inv_out)
    );

    // mode select for result and next chain value
    always_comb
    begin
        unique case (cfg.mode)
            tscm_pkg::MODE_CBC:
            begin
                if (cfg.dir == tscm_pkg::DIR_ENCRYPT)
                begin
                    result     = fwd_out;
                    chain_next = fwd_out;
                end
                else
                begin
                    result     = inv_out ^ chain_cur;
                    chain_next = s1_data_reg;
                end
            end
            tscm_pkg::MODE_OFB:
            begin
                result     = s1_data_reg ^ fwd_out;
                chain_next = fwd_out;
            end
            default:  // ECB, and the unused code
            begin
                result     = (cfg.dir == tscm_pkg::DIR_ENCRYPT) ? fwd_out : inv_out;
                chain_next = chain_cur;
            end
        endcase
    end

    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            chain_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                chain_reg <= chain_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = out_data_reg;

endmodule
